[hdl/jsu_pkg.sv]
package jsu_pkg;

    localparam int MaxRes = 4;

    typedef enum logic [1:0] {
        PH_EXPECT,
        PH_TEXT,
        PH_ESC,
        PH_HEX
    } t_phase;

    typedef enum logic [1:0] {
        K_DATA,
        K_CLOSED,
        K_NOQUOTE,
        K_UNTERM
    } t_kind;

    typedef struct packed {
        logic [7:0] data;
        t_kind      kind;
    } t_res;

    typedef struct packed {
        logic [2:0]              cnt;
        t_res [MaxRes-1:0]       res;
    } t_group;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_U      = 8'h75;

    localparam logic [7:0] CTL_LF = 8'h0A;
    localparam logic [7:0] CTL_HT = 8'h09;
    localparam logic [7:0] CTL_CR = 8'h0D;
    localparam logic [7:0] CTL_BS = 8'h08;
    localparam logic [7:0] CTL_FF = 8'h0C;

    localparam logic [15:0] UTF_LIM1 = 16'h0080;
    localparam logic [15:0] UTF_LIM2 = 16'h0800;
    localparam logic [7:0]  UTF_LEAD2 = 8'hC0;
    localparam logic [7:0]  UTF_LEAD3 = 8'hE0;
    localparam logic [7:0]  UTF_CONT  = 8'h80;

    localparam logic [2:0] HEX_DIGITS = 3'd4;

    // {valid, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, 4'(b - 8'h30)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r = {1'b1, 4'(b - 8'h57)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        return r;
    endfunction

endpackage

[hdl/jsu_parse.sv]
module jsu_parse
    import jsu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    output t_group     o_group
);

    t_phase      r_phase, n_phase;
    logic [2:0]  r_hex_cnt, n_hex_cnt;
    logic [15:0] r_acc, n_acc;

    logic        tb_on;
    t_res        tb_res;
    t_phase      tb_phase;

    logic        utf_on;
    logic [15:0] utf_code;
    logic [1:0]  utf_n;
    logic [7:0]  u [MaxRes];

    logic        tail_on;
    t_res        tail;

    logic [4:0]  hx;
    logic [15:0] acc_up;
    logic [2:0]  cnt_up;

    // plain text byte handling, shared by text phase and short hex escape
    always_comb begin
        tb_on    = 1'b1;
        tb_res   = '{data: i_byte, kind: K_DATA};
        tb_phase = PH_TEXT;
        if (i_byte == CH_NUL) begin
            tb_res   = '{data: 8'd0, kind: K_UNTERM};
            tb_phase = PH_EXPECT;
        end else if (i_byte == CH_QUOTE) begin
            tb_res   = '{data: 8'd0, kind: K_CLOSED};
            tb_phase = PH_EXPECT;
        end else if (i_byte == CH_BSLASH) begin
            tb_on    = 1'b0;
            tb_phase = PH_ESC;
        end
    end

    always_comb begin
        hx      = hex_digit(i_byte);
        acc_up  = {r_acc[11:0], hx[3:0]};
        cnt_up  = r_hex_cnt + 3'd1;

        n_phase   = r_phase;
        n_hex_cnt = r_hex_cnt;
        n_acc     = r_acc;
        utf_on    = 1'b0;
        utf_code  = 16'd0;
        tail_on   = 1'b0;
        tail      = '{data: 8'd0, kind: K_DATA};

        case (r_phase)
            PH_EXPECT: begin
                if (i_byte == CH_QUOTE) begin
                    n_phase = PH_TEXT;
                end else begin
                    tail_on = 1'b1;
                    tail    = '{data: 8'd0, kind: K_NOQUOTE};
                end
            end
            PH_TEXT: begin
                tail_on = tb_on;
                tail    = tb_res;
                n_phase = tb_phase;
            end
            PH_ESC: begin
                n_phase = PH_TEXT;
                tail_on = 1'b1;
                tail    = '{data: i_byte, kind: K_DATA};
                case (i_byte)
                    CH_NUL: begin
                        tail    = '{data: 8'd0, kind: K_UNTERM};
                        n_phase = PH_EXPECT;
                    end
                    CH_N: tail.data = CTL_LF;
                    CH_T: tail.data = CTL_HT;
                    CH_R: tail.data = CTL_CR;
                    CH_B: tail.data = CTL_BS;
                    CH_F: tail.data = CTL_FF;
                    CH_U: begin
                        tail_on   = 1'b0;
                        n_phase   = PH_HEX;
                        n_hex_cnt = 3'd0;
                        n_acc     = 16'd0;
                    end
                    default: tail.data = i_byte;
                endcase
            end
            PH_HEX: begin
                if (hx[4]) begin
                    if (cnt_up >= HEX_DIGITS) begin
                        utf_on    = 1'b1;
                        utf_code  = acc_up;
                        n_phase   = PH_TEXT;
                        n_hex_cnt = 3'd0;
                        n_acc     = 16'd0;
                    end else begin
                        n_acc     = acc_up;
                        n_hex_cnt = cnt_up;
                    end
                end else begin
                    utf_on    = 1'b1;
                    utf_code  = r_acc;
                    n_hex_cnt = 3'd0;
                    n_acc     = 16'd0;
                    tail_on   = tb_on;
                    tail      = tb_res;
                    n_phase   = tb_phase;
                end
            end
            default: n_phase = PH_EXPECT;
        endcase
    end

    // utf-8 encoding of the code point
    always_comb begin
        u[0] = 8'd0;
        u[1] = 8'd0;
        u[2] = 8'd0;
        u[3] = 8'd0;
        if (utf_code < UTF_LIM1) begin
            utf_n = 2'd1;
            u[0]  = utf_code[7:0];
        end else if (utf_code < UTF_LIM2) begin
            utf_n = 2'd2;
            u[0]  = UTF_LEAD2 | {3'd0, utf_code[10:6]};
            u[1]  = UTF_CONT | {2'd0, utf_code[5:0]};
        end else begin
            utf_n = 2'd3;
            u[0]  = UTF_LEAD3 | {4'd0, utf_code[15:12]};
            u[1]  = UTF_CONT | {2'd0, utf_code[11:6]};
            u[2]  = UTF_CONT | {2'd0, utf_code[5:0]};
        end
        if (!utf_on) begin
            utf_n = 2'd0;
        end
    end

    always_comb begin
        o_group.cnt = {1'b0, utf_n} + {2'd0, tail_on};
        for (int i = 0; i < MaxRes; i++) begin
            if (2'(i) < utf_n) begin
                o_group.res[i] = '{data: u[i], kind: K_DATA};
            end else begin
                o_group.res[i] = tail;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_EXPECT;
            r_hex_cnt <= 3'd0;
            r_acc     <= 16'd0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_hex_cnt <= n_hex_cnt;
            r_acc     <= n_acc;
        end
    end

endmodule

[hdl/jsu_out.sv]
module jsu_out
    import jsu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_group     i_group,
    output logic       o_free,
    output logic       o_tvalid,
    input  logic       i_tready,
    output logic [7:0] o_tdata,
    output logic [1:0] o_tuser,
    output logic       o_tlast
);

    logic [2:0]        r_cnt;
    logic [1:0]        r_idx;
    t_res [MaxRes-1:0] r_res;
    logic              last_word;
    logic              done;

    assign o_tvalid  = (r_cnt != 3'd0);
    assign last_word = ({1'b0, r_idx} == (r_cnt - 3'd1));
    assign done      = o_tvalid && i_tready && last_word;
    assign o_free    = !o_tvalid || done;

    assign o_tdata = r_res[r_idx].data;
    assign o_tuser = r_res[r_idx].kind;
    assign o_tlast = last_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
            r_idx <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_group.cnt;
            r_idx <= 2'd0;
        end else if (done) begin
            r_cnt <= 3'd0;
            r_idx <= 2'd0;
        end else if (o_tvalid && i_tready) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_group.res;
        end
    end

endmodule

[hdl/json_string_unescape_utf8_core.sv]
// channel   dir  tdata            tuser      tlast
// s (in)    in   [7:0] in_byte    -          -
// m (out)   out  [7:0] out_byte   [1:0] kind last
//
// one input byte per cycle while output is ready and each byte yields at
// most one word; a byte that yields several words holds the input while
// the result buffer drains. bytes that yield no word never hold the input.
// reset is synchronous, active low, and returns the parser to the
// expect-opening-quote state with an empty result buffer.
// input ready follows output ready combinationally on the last word.
module json_string_unescape_utf8_core
    import jsu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,  // [7:0] in_byte
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,  // [7:0] out_byte
    output logic [1:0] o_m_tuser,  // [1:0] kind
    output logic       o_m_tlast
);

    logic   accept;
    logic   free;
    t_group group;

    assign o_s_tready = free;
    assign accept     = i_s_tvalid && free;

    jsu_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_s_tdata),
        .o_group  (group)
    );

    jsu_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept),
        .i_group  (group),
        .o_free   (free),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_tdata  (o_m_tdata),
        .o_tuser  (o_m_tuser),
        .o_tlast  (o_m_tlast)
    );

    a_ready_only_on_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_s_tready && o_m_tvalid) |-> (i_m_tready && o_m_tlast))
        else $error("input taken while result group still pending");

    a_status_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser != K_DATA)) |-> o_m_tlast)
        else $error("status word not marked last");

    a_status_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser != K_DATA)) |-> (o_m_tdata == 8'd0))
        else $error("status word carries data");

endmodule
